// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// MLFQ thread scheduler package
// Request and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned ID_W       = 8;
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned LEVEL_OUT_W = 2;
  localparam int unsigned ID_SPACE   = 1 << ID_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 3'd0,
    REQ_EXPIRE = 3'd1,
    REQ_YIELD  = 3'd2,
    REQ_BLOCK  = 3'd3,
    REQ_EXIT   = 3'd4,
    REQ_UNLOCK = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NO_RUN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CREATE,
    S_CUR,
    S_DISPATCH,
    S_DISP_TAKE,
    S_UNL_CHECK,
    S_UNL_BS,
    S_UNL_PUSH,
    S_FIN_RD,
    S_FIN
  } state_e;

  // source of a level enqueue
  typedef enum logic [1:0] {
    PUSH_NONE,
    PUSH_CREATE,
    PUSH_RUN,
    PUSH_BLK
  } push_e;

  // thread level lookup address select
  typedef enum logic {
    TL_RUN,
    TL_BLK
  } tl_sel_e;

  typedef struct packed {
    logic    latch;
    push_e   push_op;
    tl_sel_e tl_sel;
    logic    expire;
    logic    blk_push;
    logic    blk_pop;
    logic    clr_run;
    logic    disp_take;
    logic    disp_none;
    logic    out_load;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic run_valid;
    logic push_full;
    logic blk_full;
    logic blk_empty;
    logic any_ready;
    logic out_busy;
  } sts_t;

endpackage

// File: hw/rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on collision
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hw/rtl/mts_ctrl.sv
// ----------------------------------------------------------------------------
// MLFQ scheduler controller
// Sequences one request through lookup, enqueue, dispatch and result.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [mts_pkg::REQ_W-1:0] req_type_i,
  input  mts_pkg::sts_t          sts_i,
  output mts_pkg::cmd_t          cmd_o
);
  import mts_pkg::*;

  state_e  state_q, state_d;
  req_e    req_q, req_d;
  status_e status_q, status_d;

  // state and request registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      req_q    <= REQ_CREATE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      req_q    <= req_d;
      status_q <= status_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d         = state_q;
    req_d           = req_q;
    status_d        = status_q;
    in_stall_o      = 1'b1;
    cmd_o.latch     = 1'b0;
    cmd_o.push_op   = PUSH_NONE;
    cmd_o.tl_sel    = TL_RUN;
    cmd_o.expire    = (req_q == REQ_EXPIRE);
    cmd_o.blk_push  = 1'b0;
    cmd_o.blk_pop   = 1'b0;
    cmd_o.clr_run   = 1'b0;
    cmd_o.disp_take = 1'b0;
    cmd_o.disp_none = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.status    = status_q;

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          req_d       = req_e'(req_type_i);
          status_d    = ST_OK;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (req_q)
          REQ_CREATE: state_d = S_CREATE;
          REQ_EXPIRE, REQ_YIELD, REQ_BLOCK, REQ_EXIT: begin
            if (sts_i.run_valid) begin
              state_d = S_CUR;
            end else begin
              status_d = ST_NO_RUN;
              state_d  = S_DISPATCH;
            end
          end
          REQ_UNLOCK: state_d = S_UNL_CHECK;
          default:    state_d = S_FIN_RD;
        endcase
      end
      S_CREATE: begin
        cmd_o.push_op = PUSH_CREATE;
        if (sts_i.push_full) begin
          status_d = ST_FULL;
        end
        state_d = S_FIN_RD;
      end
      // level of the running thread is valid here
      S_CUR: begin
        unique case (req_q)
          REQ_EXPIRE, REQ_YIELD: begin
            cmd_o.push_op = PUSH_RUN;
            if (sts_i.push_full) begin
              status_d = ST_FULL;
              state_d  = S_FIN_RD;
            end else begin
              cmd_o.clr_run = 1'b1;
              state_d       = S_DISPATCH;
            end
          end
          REQ_BLOCK: begin
            if (sts_i.blk_full) begin
              status_d = ST_FULL;
              state_d  = S_FIN_RD;
            end else begin
              cmd_o.blk_push = 1'b1;
              cmd_o.clr_run  = 1'b1;
              state_d        = S_DISPATCH;
            end
          end
          default: begin
            cmd_o.clr_run = 1'b1;
            state_d       = S_DISPATCH;
          end
        endcase
      end
      S_DISPATCH: begin
        if (sts_i.any_ready) begin
          state_d = S_DISP_TAKE;
        end else begin
          cmd_o.disp_none = 1'b1;
          state_d         = S_FIN_RD;
        end
      end
      S_DISP_TAKE: begin
        cmd_o.disp_take = 1'b1;
        state_d         = S_FIN_RD;
      end
      // unlock drain: each blocked entry steps through S_UNL_CHECK, S_UNL_BS and S_UNL_PUSH
      S_UNL_CHECK: begin
        state_d = sts_i.blk_empty ? S_FIN_RD : S_UNL_BS;
      end
      S_UNL_BS: begin
        cmd_o.tl_sel = TL_BLK;
        state_d      = S_UNL_PUSH;
      end
      S_UNL_PUSH: begin
        cmd_o.tl_sel  = TL_BLK;
        cmd_o.push_op = PUSH_BLK;
        if (sts_i.push_full) begin
          status_d = ST_FULL;
          state_d  = S_FIN_RD;
        end else begin
          cmd_o.blk_pop = 1'b1;
          state_d       = S_UNL_CHECK;
        end
      end
      S_FIN_RD: state_d = S_FIN;
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mts_datapath.sv
// ----------------------------------------------------------------------------
// MLFQ scheduler datapath
// Level queues, blocked queue, thread levels, running thread and result.
// ----------------------------------------------------------------------------
module mts_datapath #(
  parameter int unsigned THREAD_COUNT = 256,
  parameter int unsigned LEVEL_COUNT  = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic [mts_pkg::ID_W-1:0]    new_thread_i,
  input  mts_pkg::cmd_t               cmd_i,
  output mts_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        run_valid_o,
  output logic [mts_pkg::ID_W-1:0]    run_thread_o,
  output logic [mts_pkg::LEVEL_OUT_W-1:0] run_level_o,
  output logic [mts_pkg::STATUS_W-1:0] status_o
);
  import mts_pkg::*;

  localparam int unsigned LW  = $clog2(LEVEL_COUNT);
  localparam int unsigned HW  = $clog2(THREAD_COUNT);
  localparam int unsigned CW  = $clog2(THREAD_COUNT + 1);
  localparam int unsigned SAW = $clog2(LEVEL_COUNT * THREAD_COUNT);
  localparam logic [LW-1:0] TOP = LW'(LEVEL_COUNT - 1);

  logic            en_q;
  logic [ID_W-1:0] id_q;
  logic            run_valid_q;
  logic [ID_W-1:0] run_thread_q;
  logic [HW-1:0]   heads_q [LEVEL_COUNT];
  logic [CW-1:0]   counts_q [LEVEL_COUNT];
  logic [HW-1:0]   bhead_q;
  logic [CW-1:0]   bcount_q;
  logic            out_valid_q;

  logic [ID_W-1:0] ls_rdata, bs_rdata;
  logic [LW-1:0]   tl_rdata;
  logic [ID_W-1:0] tl_raddr;

  logic [LW-1:0]   disp_lvl, tgt_lvl, acc_lvl;
  logic            any_ready;
  logic [ID_W-1:0] push_id;
  logic            push_act, push_full, push_we;
  logic [HW-1:0]   head_sel;
  logic [CW-1:0]   count_sel;
  logic [CW:0]     tail_sum, btail_sum;
  logic [HW-1:0]   tail, btail;
  logic [SAW-1:0]  ls_waddr, ls_raddr;

  // highest nonempty level
  always_comb begin
    disp_lvl  = '0;
    any_ready = 1'b0;
    for (int l = 0; l < LEVEL_COUNT; l++) begin
      if (counts_q[l] != '0) begin
        disp_lvl  = LW'(l);
        any_ready = 1'b1;
      end
    end
  end

  // enqueue source and target level
  always_comb begin
    push_id = id_q;
    tgt_lvl = TOP;
    case (cmd_i.push_op)
      PUSH_RUN: begin
        push_id = run_thread_q;
        if (en_q) begin
          tgt_lvl = (cmd_i.expire && tl_rdata != '0) ? tl_rdata - LW'(1) : tl_rdata;
        end
      end
      PUSH_BLK: begin
        push_id = bs_rdata;
        if (en_q) begin
          tgt_lvl = tl_rdata;
        end
      end
      default: ;
    endcase
  end

  // one level is accessed per cycle: the enqueue target or the dispatch level
  assign push_act  = (cmd_i.push_op != PUSH_NONE);
  assign acc_lvl   = push_act ? tgt_lvl : disp_lvl;
  assign head_sel  = heads_q[acc_lvl];
  assign count_sel = counts_q[acc_lvl];
  assign push_full = push_act && (count_sel == CW'(THREAD_COUNT));
  assign push_we   = push_act && !push_full;

  // tail index with one wrap
  assign tail_sum = (CW+1)'(head_sel) + (CW+1)'(count_sel);
  assign tail     = (tail_sum >= (CW+1)'(THREAD_COUNT)) ?
                    HW'(tail_sum - (CW+1)'(THREAD_COUNT)) : HW'(tail_sum);
  assign btail_sum = (CW+1)'(bhead_q) + (CW+1)'(bcount_q);
  assign btail     = (btail_sum >= (CW+1)'(THREAD_COUNT)) ?
                     HW'(btail_sum - (CW+1)'(THREAD_COUNT)) : HW'(btail_sum);

  assign ls_waddr = SAW'(acc_lvl) * SAW'(THREAD_COUNT) + SAW'(tail);
  assign ls_raddr = SAW'(disp_lvl) * SAW'(THREAD_COUNT) + SAW'(heads_q[disp_lvl]);
  assign tl_raddr = (cmd_i.tl_sel == TL_BLK) ? bs_rdata : run_thread_q;

  // storage
  mts_ram #(.WIDTH(ID_W), .DEPTH(LEVEL_COUNT * THREAD_COUNT)) u_level_store (
    .clk_i   (clk_i),
    .we_i    (push_we),
    .waddr_i (ls_waddr),
    .wdata_i (push_id),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  mts_ram #(.WIDTH(LW), .DEPTH(ID_SPACE)) u_thread_level (
    .clk_i   (clk_i),
    .we_i    (push_we),
    .waddr_i (push_id),
    .wdata_i (tgt_lvl),
    .raddr_i (tl_raddr),
    .rdata_o (tl_rdata)
  );

  mts_ram #(.WIDTH(ID_W), .DEPTH(THREAD_COUNT)) u_blocked_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.blk_push),
    .waddr_i (btail),
    .wdata_i (run_thread_q),
    .raddr_i (bhead_q),
    .rdata_o (bs_rdata)
  );

  // configuration and request id
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (cfg_we_i) begin
      en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      id_q <= new_thread_i;
    end
  end

  // level queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        heads_q[l]  <= '0;
        counts_q[l] <= '0;
      end
    end else if (push_we) begin
      counts_q[acc_lvl] <= count_sel + CW'(1);
    end else if (cmd_i.disp_take) begin
      counts_q[acc_lvl] <= count_sel - CW'(1);
      heads_q[acc_lvl]  <= (head_sel == HW'(THREAD_COUNT - 1)) ? '0 : head_sel + HW'(1);
    end
  end

  // blocked queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bhead_q  <= '0;
      bcount_q <= '0;
    end else if (cmd_i.blk_push) begin
      bcount_q <= bcount_q + CW'(1);
    end else if (cmd_i.blk_pop) begin
      bcount_q <= bcount_q - CW'(1);
      bhead_q  <= (bhead_q == HW'(THREAD_COUNT - 1)) ? '0 : bhead_q + HW'(1);
    end
  end

  // running thread
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q  <= 1'b0;
      run_thread_q <= '0;
    end else if (cmd_i.disp_take) begin
      run_valid_q  <= 1'b1;
      run_thread_q <= ls_rdata;
    end else if (cmd_i.disp_none) begin
      run_valid_q  <= 1'b0;
      run_thread_q <= '0;
    end else if (cmd_i.clr_run) begin
      run_valid_q  <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      run_valid_o  <= run_valid_q;
      run_thread_o <= run_valid_q ? run_thread_q : '0;
      run_level_o  <= run_valid_q ? LEVEL_OUT_W'(tl_rdata) : '0;
      status_o     <= cmd_i.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.run_valid = run_valid_q;
  assign sts_o.push_full = push_full;
  assign sts_o.blk_full  = (bcount_q == CW'(THREAD_COUNT));
  assign sts_o.blk_empty = (bcount_q == '0);
  assign sts_o.any_ready = any_ready;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;

endmodule

// File: hw/rtl/mlfq_thread_scheduler.sv
// ----------------------------------------------------------------------------
// MLFQ thread scheduler
// Four-level feedback queue scheduler with a blocked queue, one event a time.
// ----------------------------------------------------------------------------
// From accept to result a request steps through decode, its request states and the
// result read, sequenced by the controller around the RAM reads; unlock adds a pass
// per drained entry, and a result stall holds the result load.
// One request in flight; the next is accepted in the cycle after the result loads.
// Reset clears queue pointers, the running thread and sets feedback mode on;
// queue stores need no clearing pass.
module mlfq_thread_scheduler #(
  parameter int unsigned THREAD_COUNT = 256,
  parameter int unsigned LEVEL_COUNT  = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [mts_pkg::REQ_W-1:0]        req_type_i,
  input  logic [mts_pkg::ID_W-1:0]         new_thread_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             run_valid_o,
  output logic [mts_pkg::ID_W-1:0]         run_thread_o,
  output logic [mts_pkg::LEVEL_OUT_W-1:0]  run_level_o,
  output logic [mts_pkg::STATUS_W-1:0]     status_o
);
  import mts_pkg::*;
`include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mts_datapath #(
    .THREAD_COUNT (THREAD_COUNT),
    .LEVEL_COUNT  (LEVEL_COUNT)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .new_thread_i (new_thread_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .run_valid_o  (run_valid_o),
    .run_thread_o (run_thread_o),
    .run_level_o  (run_level_o),
    .status_o     (status_o)
  );

  // a request is in flight right after it is taken
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)
  // a result never overwrites one still waiting
  `ASSERT_NEVER(a_no_result_drop, clk_i, rst_ni, cmd.out_load && sts.out_busy)
  // with nothing dispatched the thread and level read as zero
  `ASSERT_NEVER(a_idle_zero, clk_i, rst_ni, out_valid_o && !run_valid_o && (run_thread_o != '0 || run_level_o != '0))

endmodule
